[hw/rtl/desv_pkg.sv]
// Shared constants, permutation tables and bit-routing functions for the DES variant block.
package desv_pkg;

   localparam int MAX_ROUNDS   = 16;
   localparam int TABLE_COUNT  = 8;
   localparam int TABLE_DEPTH  = 64;
   localparam int SBOX_COUNT   = 8;
   localparam int SBOX_DEPTH   = TABLE_COUNT * TABLE_DEPTH;
   localparam int SBOX_ADDR_W  = $clog2(SBOX_DEPTH);
   localparam int SEL_W        = $clog2(TABLE_COUNT);
   localparam int ENTRY_ADDR_W = $clog2(TABLE_DEPTH);
   localparam int SBOX_DATA_W  = 4;
   localparam int ROUND_W      = 5;
   localparam int ROUND_IDX_W  = $clog2(MAX_ROUNDS);
   localparam int ORDER_W      = SEL_W * SBOX_COUNT;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = ORDER_W;

   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = ROUND_W'(MAX_ROUNDS);
   localparam logic [ORDER_W-1:0] SBOX_ORDER_RESET  = 24'hFAC688;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SBOX_ORDER  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_MODE    = 2'd2;

   // Request kinds.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ENCRYPT = 1'b1;

   localparam logic [6:0] IP_TAB [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

   localparam logic [5:0] E_TAB [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

   localparam logic [5:0] P_TAB [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

   localparam logic [6:0] PC1_TAB [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
      7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

   localparam logic [5:0] PC2_TAB [48] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

   // Bit k (counting from the left) is set where round k rotates the key halves by two.
   localparam logic [0:MAX_ROUNDS-1] ROT_TWO = 16'b0011_1111_0111_1110;

   function automatic logic [63:0] ip_perm(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(IP_TAB[i])];
      return r;
   endfunction

   function automatic logic [63:0] inv_ip_perm(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) r[64 - int'(IP_TAB[i])] = x[63-i];
      return r;
   endfunction

   function automatic logic [55:0] pc1_perm(input logic [63:0] x);
      logic [55:0] r;
      r = '0;
      for (int i = 0; i < 56; i++) r[55-i] = x[64 - int'(PC1_TAB[i])];
      return r;
   endfunction

   function automatic logic [47:0] pc2_perm(input logic [55:0] x);
      logic [47:0] r;
      r = '0;
      for (int i = 0; i < 48; i++) r[47-i] = x[56 - int'(PC2_TAB[i])];
      return r;
   endfunction

   function automatic logic [47:0] e_expand(input logic [31:0] x);
      logic [47:0] r;
      r = '0;
      for (int i = 0; i < 48; i++) r[47-i] = x[32 - int'(E_TAB[i])];
      return r;
   endfunction

   function automatic logic [31:0] p_perm(input logic [31:0] x);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) r[31-i] = x[32 - int'(P_TAB[i])];
      return r;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] v, input logic two);
      return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
   endfunction

   // Table entry from the six S-box input bits: outer bits pick the row, as in standard DES.
   function automatic logic [ENTRY_ADDR_W-1:0] sbox_entry(input logic [5:0] six);
      return {six[5], six[0], six[4:1]};
   endfunction

endpackage

[hw/rtl/desv_if.sv]
// Valid/ready channel interfaces for the request and response transactions.
interface desv_req_if;
   import desv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [SEL_W-1:0]        table_select;
   logic [ENTRY_ADDR_W-1:0] table_addr;
   logic [SBOX_DATA_W-1:0]  table_value;
   logic [63:0]             plaintext;
   logic [63:0]             key_value;

   modport source (output valid, req_type, table_select, table_addr, table_value,
                   plaintext, key_value, input ready);
   modport sink (input valid, req_type, table_select, table_addr, table_value,
                 plaintext, key_value, output ready);
endinterface

interface desv_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] ciphertext;

   modport source (output valid, ciphertext, input ready);
   modport sink (input valid, ciphertext, output ready);
endinterface

[hw/rtl/des_variant_block_encrypt_unit.sv]
// Top level of the reduced-round DES block encrypt unit with loadable S-box tables.
//
//   channel  direction  handshake          contents
//   req_chan in         valid/ready        load of one S-box entry, or block + key to encrypt
//   rsp_chan out        valid/ready        ciphertext, one per encrypt transaction
//   csr_*    in         write enable only  round_count, sbox_order, key_mode
//
// An encrypt runs R = min(round_count, 16) Feistel rounds; each round has a read step that
// issues the eight S-box reads and a round step that consumes the registered read data,
// since the next round's addresses depend on that data.
// The S-box tables are replicated in eight RAMs, one per S-box position, so a round reads all
// eight positions at once. Reset is synchronous; it clears control state and settings, not
// the data registers or the tables. The result waits in an output register; a new request
// is taken while it waits; a finished encrypt stalls only if the prior result is not taken.
module des_variant_block_encrypt_unit (
   input  logic                             clock,
   input  logic                             reset,
   desv_req_if.sink                         req_chan,
   desv_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [desv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [desv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import desv_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [ROUND_W-1:0]     round_count_ff, round_count_in;
   logic [ORDER_W-1:0]     sbox_order_ff, sbox_order_in;
   logic                   key_mode_ff, key_mode_in;
   logic [27:0]            c_ff, c_in, d_ff, d_in;
   logic [31:0]            l_ff, l_in, r_ff, r_in;
   logic [ROUND_IDX_W-1:0] k_ff, k_in;
   logic [ROUND_W-1:0]     rounds_ff, rounds_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            ciphertext_ff, ciphertext_in;

   logic                   req_fire;
   logic                   load_fire;
   logic                   encrypt_fire;
   logic [55:0]            cd_start;
   logic [63:0]            blk_start;
   logic [ROUND_W-1:0]     rounds_sat;
   logic [27:0]            c_rot, d_rot;
   logic [47:0]            sbox_in;
   logic [31:0]            sbox_out;
   logic [31:0]            f_out;
   logic                   last_round;
   logic                   out_free;
   logic [SBOX_ADDR_W-1:0] wr_addr;
   logic [SBOX_ADDR_W-1:0] rd_addr [SBOX_COUNT];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_fire      = req_fire && (req_chan.req_type == REQ_LOAD);
   assign encrypt_fire   = req_fire && (req_chan.req_type == REQ_ENCRYPT);

   assign cd_start   = key_mode_ff ? req_chan.key_value[55:0] : pc1_perm(req_chan.key_value);
   assign blk_start  = ip_perm(req_chan.plaintext);
   assign rounds_sat = (round_count_ff > ROUND_W'(MAX_ROUNDS)) ? ROUND_W'(MAX_ROUNDS)
                                                                : round_count_ff;

   // The key rotation of the current round feeds the S-box addresses in the read cycle.
   assign c_rot   = rotl28(c_ff, ROT_TWO[k_ff]);
   assign d_rot   = rotl28(d_ff, ROT_TWO[k_ff]);
   assign sbox_in = e_expand(r_ff) ^ pc2_perm({c_rot, d_rot});
   assign wr_addr = {req_chan.table_select, req_chan.table_addr};

   for (genvar p = 0; p < SBOX_COUNT; p++) begin : g_sbox
      assign rd_addr[p] = {sbox_order_ff[SEL_W*p +: SEL_W],
                           sbox_entry(sbox_in[47-6*p -: 6])};

      desv_ram #(
         .WIDTH (SBOX_DATA_W),
         .DEPTH (SBOX_DEPTH)
      ) u_sbox_ram (
         .clock   (clock),
         .wr_en   (load_fire),
         .wr_addr (wr_addr),
         .wr_data (req_chan.table_value),
         .rd_addr (rd_addr[p]),
         .rd_data (sbox_out[31-SBOX_DATA_W*p -: SBOX_DATA_W])
      );
   end

   assign f_out      = p_perm(sbox_out);
   assign last_round = ((ROUND_W'(k_ff) + ROUND_W'(1)) == rounds_ff);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      round_count_in = round_count_ff;
      sbox_order_in  = sbox_order_ff;
      key_mode_in    = key_mode_ff;
      c_in           = c_ff;
      d_in           = d_ff;
      l_in           = l_ff;
      r_in           = r_ff;
      k_in           = k_ff;
      rounds_in      = rounds_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      ciphertext_in  = ciphertext_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROUND_COUNT: round_count_in = csr_wdata[ROUND_W-1:0];
            CSR_SBOX_ORDER:  sbox_order_in  = csr_wdata[ORDER_W-1:0];
            CSR_KEY_MODE:    key_mode_in    = csr_wdata[0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (encrypt_fire) begin
               c_in      = cd_start[55:28];
               d_in      = cd_start[27:0];
               l_in      = blk_start[63:32];
               r_in      = blk_start[31:0];
               k_in      = '0;
               rounds_in = rounds_sat;
               state_in  = (rounds_sat == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            c_in     = c_rot;
            d_in     = d_rot;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            l_in     = r_ff;
            r_in     = l_ff ^ f_out;
            k_in     = k_ff + ROUND_IDX_W'(1);
            state_in = last_round ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (out_free) begin
               ciphertext_in = inv_ip_perm({r_ff, l_ff});
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         round_count_ff <= ROUND_COUNT_RESET;
         sbox_order_ff  <= SBOX_ORDER_RESET;
         key_mode_ff    <= 1'b0;
         k_ff           <= '0;
         rounds_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_count_ff <= round_count_in;
         sbox_order_ff  <= sbox_order_in;
         key_mode_ff    <= key_mode_in;
         k_ff           <= k_in;
         rounds_ff      <= rounds_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      c_ff          <= c_in;
      d_ff          <= d_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      ciphertext_ff <= ciphertext_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ciphertext = ciphertext_ff;

   // A round only consumes S-box data that was addressed in the cycle before.
   a_round_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> $past(state_ff == ST_READ))
      else $error("round step without a preceding S-box read");

   // The round index stays below the saturated round count while rounds run.
   a_round_index_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_ROUND)) |->
         ((ROUND_W'(k_ff) < rounds_ff) && (rounds_ff <= ROUND_W'(MAX_ROUNDS))))
      else $error("round index out of range");

   // A new result appears only when an encryption finishes.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   // A pending result that is not taken is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && rsp_valid_ff && !rsp_chan.ready) |=>
         ((state_ff == ST_FINISH) && $stable(ciphertext_ff)))
      else $error("finished block overwrote a pending response");

   // No request is taken while an encryption is in flight.
   a_busy_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      $past(encrypt_fire) |-> !req_chan.ready)
      else $error("request accepted during an encryption");
endmodule

[hw/rtl/desv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module desv_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
